@@ design/qidt_pkg.sv @@
package qidt_pkg;

  parameter int unsigned POOL_SIZE_DEF = 256;

  parameter logic [7:0] HOLD_TIMEOUT_RST = 8'd2;

  parameter int unsigned STAMP_W = 32;
  parameter int unsigned META_W  = STAMP_W + 1;
  parameter int unsigned DATA_W  = 64;

  parameter int unsigned PADDR_W = 3;
  parameter logic [PADDR_W-1:0] REG_HOLD_TIMEOUT_ADDR = 3'd0;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_LOOKUP  = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_TICK    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_HELD = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_RESP
  } state_e;

endpackage

@@ design/qidt_ram.sv @@
module qidt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/query_id_translation_table_unit.sv @@
// Responses: tick, pool full and out-of-range slot answer in the cycle after accept;
// lookup and release pass through the check state first; allocate passes through the
// scan state, which skips slots until a reusable one, one slot read and age compare per cycle.
// Flow: one request at a time; the next is taken in the cycle after the result leaves.
// Reset: asynchronous, active low; a clearing pass over all POOL_SIZE slots then marks
// every slot free before the first request is taken.
module query_id_translation_table_unit #(
  parameter int unsigned POOL_SIZE = qidt_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [15:0]                  client_id_i,
  input  logic [31:0]                  client_addr_i,
  input  logic [15:0]                  client_port_i,
  input  logic [7:0]                   slot_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [7:0]                   slot_out_o,
  output logic [15:0]                  client_id_out_o,
  output logic [31:0]                  client_addr_out_o,
  output logic [15:0]                  client_port_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qidt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned SLOT_W = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int unsigned EXT_W  = (SLOT_W > 8) ? SLOT_W : 8;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);

  qidt_pkg::state_e state_q, state_d;

  logic [7:0]        timeout_q;
  logic [SLOT_W-1:0] next_slot_q, next_slot_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [31:0]       now_q, now_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] clr_q, clr_d;

  logic [1:0]  mode_q, mode_d;
  logic [15:0] cid_q, cid_d;
  logic [31:0] caddr_q, caddr_d;
  logic [15:0] cport_q, cport_d;

  logic [1:0]  status_q, status_d;
  logic [7:0]  sout_q, sout_d;
  logic [15:0] oid_q, oid_d;
  logic [31:0] oaddr_q, oaddr_d;
  logic [15:0] oport_q, oport_d;

  logic                          meta_we, data_we;
  logic [SLOT_W-1:0]             waddr, raddr;
  logic [qidt_pkg::META_W-1:0]   meta_wdata, meta_rdata;
  logic [qidt_pkg::DATA_W-1:0]   data_rdata;
  logic [EXT_W-1:0]              slot_ext;
  logic                          slot_in_range;
  logic                          held;
  logic [31:0]                   age;
  logic                          reusable;
  logic                          in_acc;
  logic                          cfg_we;

  assign slot_ext      = EXT_W'(slot_i);
  assign slot_in_range = (32'(slot_i) < 32'(POOL_SIZE));
  assign held          = meta_rdata[qidt_pkg::META_W-1];
  assign age           = now_q - meta_rdata[qidt_pkg::STAMP_W-1:0];
  assign reusable      = !held || (age >= 32'(timeout_q));

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s);
    wrap_inc = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  qidt_ram #(.WIDTH(qidt_pkg::META_W), .DEPTH(POOL_SIZE)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wdata),
    .raddr_i (raddr),
    .rdata_o (meta_rdata)
  );

  qidt_ram #(.WIDTH(qidt_pkg::DATA_W), .DEPTH(POOL_SIZE)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (waddr),
    .wdata_i ({cid_q, caddr_q, cport_q}),
    .raddr_i (raddr),
    .rdata_o (data_rdata)
  );

  assign in_ready_o = (state_q == qidt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qidt_pkg::REG_HOLD_TIMEOUT_ADDR[2]) ? 32'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= qidt_pkg::HOLD_TIMEOUT_RST;
    end else if (cfg_we && (paddr[2] == qidt_pkg::REG_HOLD_TIMEOUT_ADDR[2])) begin
      timeout_q <= pwdata[7:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    next_slot_d = next_slot_q;
    free_d      = free_q;
    now_d       = now_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    cid_d       = cid_q;
    caddr_d     = caddr_q;
    cport_d     = cport_q;
    status_d    = status_q;
    sout_d      = sout_q;
    oid_d       = oid_q;
    oaddr_d     = oaddr_q;
    oport_d     = oport_q;
    meta_we     = 1'b0;
    data_we     = 1'b0;
    waddr       = pos_q;
    meta_wdata  = {1'b1, now_q};
    raddr       = pos_q;

    case (state_q)
      qidt_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        waddr      = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + SLOT_W'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = qidt_pkg::ST_IDLE;
        end
      end
      qidt_pkg::ST_IDLE: begin
        raddr = (mode_i == qidt_pkg::MODE_ALLOC) ? next_slot_q : slot_ext[SLOT_W-1:0];
        if (in_acc) begin
          mode_d   = mode_i;
          cid_d    = client_id_i;
          caddr_d  = client_addr_i;
          cport_d  = client_port_i;
          pos_d    = next_slot_q;
          status_d = qidt_pkg::STATUS_OK;
          sout_d   = slot_i;
          oid_d    = '0;
          oaddr_d  = '0;
          oport_d  = '0;
          case (qidt_pkg::mode_e'(mode_i))
            qidt_pkg::MODE_ALLOC: begin
              sout_d = '0;
              if (free_q == '0) begin
                status_d = qidt_pkg::STATUS_FULL;
                state_d  = qidt_pkg::ST_RESP;
              end else begin
                state_d = qidt_pkg::ST_SCAN;
              end
            end
            qidt_pkg::MODE_LOOKUP, qidt_pkg::MODE_RELEASE: begin
              if (slot_in_range) begin
                pos_d   = slot_ext[SLOT_W-1:0];
                state_d = qidt_pkg::ST_CHECK;
              end else begin
                status_d = qidt_pkg::STATUS_NOT_HELD;
                state_d  = qidt_pkg::ST_RESP;
              end
            end
            qidt_pkg::MODE_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = qidt_pkg::ST_RESP;
            end
            default: begin
              state_d = qidt_pkg::ST_RESP;
            end
          endcase
        end
      end
      qidt_pkg::ST_SCAN: begin
        raddr = wrap_inc(pos_q);
        if (reusable) begin
          meta_we     = 1'b1;
          data_we     = 1'b1;
          meta_wdata  = {1'b1, now_q};
          next_slot_d = wrap_inc(pos_q);
          sout_d      = 8'(pos_q);
          state_d     = qidt_pkg::ST_RESP;
          if (!held) begin
            free_d = free_q - CNT_W'(1);
          end
        end else begin
          pos_d = wrap_inc(pos_q);
        end
      end
      qidt_pkg::ST_CHECK: begin
        state_d = qidt_pkg::ST_RESP;
        if (!held) begin
          status_d = qidt_pkg::STATUS_NOT_HELD;
        end else if (mode_q == qidt_pkg::MODE_LOOKUP) begin
          oid_d   = {data_rdata[55:48], data_rdata[63:56]};
          oaddr_d = data_rdata[47:16];
          oport_d = data_rdata[15:0];
        end else begin
          meta_we    = 1'b1;
          meta_wdata = {1'b0, meta_rdata[qidt_pkg::STAMP_W-1:0]};
          free_d     = free_q + CNT_W'(1);
        end
      end
      qidt_pkg::ST_RESP: begin
        if (out_ready_i) begin
          state_d = qidt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qidt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qidt_pkg::ST_CLEAR;
      next_slot_q <= '0;
      free_q      <= CNT_W'(POOL_SIZE);
      now_q       <= '0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      next_slot_q <= next_slot_d;
      free_q      <= free_d;
      now_q       <= now_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    mode_q   <= mode_d;
    cid_q    <= cid_d;
    caddr_q  <= caddr_d;
    cport_q  <= cport_d;
    status_q <= status_d;
    sout_q   <= sout_d;
    oid_q    <= oid_d;
    oaddr_q  <= oaddr_d;
    oport_q  <= oport_d;
  end

  assign out_valid_o       = (state_q == qidt_pkg::ST_RESP);
  assign status_o          = status_q;
  assign slot_out_o        = sout_q;
  assign client_id_out_o   = oid_q;
  assign client_addr_out_o = oaddr_q;
  assign client_port_out_o = oport_q;

`ifndef SYNTHESIS
  a_scan_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qidt_pkg::ST_SCAN) |-> (free_q != '0))
    else $error("scan started with no free slot");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q <= CNT_W'(POOL_SIZE)))
    else $error("free count above pool size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_full_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_q == qidt_pkg::STATUS_FULL)) |->
      (mode_q == qidt_pkg::MODE_ALLOC))
    else $error("pool full reported for a non-allocate request");
`endif

endmodule
